// ----- sv/rbb_pkg.sv -----
package rbb_pkg;

  localparam int COORD_W    = 12;
  localparam int RING_W     = 4;
  localparam int PIX_W      = 24;
  localparam int SUM_W      = 16;
  localparam int LEAD_W     = 15;
  localparam int RECIP_W    = 21;
  localparam int RECIP_SHIFT = 24;

  localparam logic [1:0] REG_KERNEL = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [3:0]         k;
    logic [2:0]         half;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [LEAD_W-1:0]  lead;
  } rbb_geom_t;

  typedef struct packed {
    logic               wr;
    logic [RING_W-1:0]  wr_ring;
    logic [COORD_W-1:0] wr_col;
    logic [PIX_W-1:0]   pixel;
    logic               emit;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [RING_W-1:0]  out_ring;
    logic               done;
  } rbb_job_t;

  function automatic logic [3:0] window_dim(input logic [1:0] sel);
    logic [3:0] k;
    unique case (sel)
      2'd0: k = 4'd3;
      2'd1: k = 4'd5;
      2'd2: k = 4'd9;
      2'd3: k = 4'd13;
      default: k = 4'd3;
    endcase
    return k;
  endfunction

  // ceil(2^24 / k^2); exact floor for every window sum of 8-bit pixels
  function automatic logic [RECIP_W-1:0] area_recip(input logic [3:0] k);
    logic [RECIP_W-1:0] r;
    unique case (k)
      4'd3:  r = 21'd1864136;
      4'd4:  r = 21'd1048576;
      4'd5:  r = 21'd671089;
      4'd6:  r = 21'd466034;
      4'd7:  r = 21'd342393;
      4'd8:  r = 21'd262144;
      4'd9:  r = 21'd207127;
      4'd10: r = 21'd167773;
      4'd11: r = 21'd138655;
      4'd12: r = 21'd116509;
      4'd13: r = 21'd99274;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/rbb_queue.sv -----
module rbb_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  rbb_pkg::rbb_job_t wr_job,
  output logic              full,
  input  logic              rd_en,
  output rbb_pkg::rbb_job_t rd_job,
  output logic              empty
);
  import rbb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rbb_job_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full   = (count == (PTR_W+1)'(DEPTH));
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en && !full, rd_en && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/rbb_front.sv -----
module rbb_front #(
  parameter int RING_ROWS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  rbb_pkg::rbb_geom_t geom,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [7:0]         pixel_red,
  input  logic [7:0]         pixel_green,
  input  logic [7:0]         pixel_blue,
  output logic               q_push,
  output rbb_pkg::rbb_job_t  q_job,
  input  logic               q_full
);
  import rbb_pkg::*;

  logic [COORD_W-1:0] in_col, in_row, out_col, out_row;
  logic [RING_W-1:0]  in_ring, out_ring;
  logic [LEAD_W-1:0]  seen;

  logic accept, complete, take_pixel, emit, done;

  assign full       = q_full;
  assign accept     = push && !q_full;
  assign complete   = (in_row >= geom.height);
  assign take_pixel = accept && (opcode == OP_PIXEL) && !complete;
  // pixel emits once the lead of half a window is buffered; drain emits after input ends
  assign emit = (take_pixel && (seen >= geom.lead)) ||
                (accept && (opcode == OP_DRAIN) && complete);
  assign done = (out_col == geom.width - 1'b1) && (out_row == geom.height - 1'b1);

  always_comb begin
    q_job          = '0;
    q_job.wr       = take_pixel;
    q_job.wr_ring  = in_ring;
    q_job.wr_col   = in_col;
    q_job.pixel    = {pixel_blue, pixel_green, pixel_red};
    q_job.emit     = emit;
    q_job.out_col  = out_col;
    q_job.out_row  = out_row;
    q_job.out_ring = out_ring;
    q_job.done     = done;
    q_push         = take_pixel || emit;
  end

  always_ff @(posedge clk) begin
    if (rst || restart || (emit && done)) begin
      in_col   <= '0;
      in_row   <= '0;
      in_ring  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_ring <= '0;
      seen     <= '0;
    end else begin
      if (take_pixel) begin
        if (seen < geom.lead) begin
          seen <= seen + 1'b1;
        end
        if (in_col == geom.width - 1'b1) begin
          in_col  <= '0;
          in_row  <= in_row + 1'b1;
          in_ring <= (in_ring == RING_W'(RING_ROWS-1)) ? '0 : in_ring + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (emit) begin
        if (out_col == geom.width - 1'b1) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_ring <= (out_ring == RING_W'(RING_ROWS-1)) ? '0 : out_ring + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/rbb_back.sv -----
module rbb_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int RING_ROWS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  rbb_pkg::rbb_geom_t geom,
  input  logic               q_empty,
  input  rbb_pkg::rbb_job_t  q_job,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         blur_red,
  output logic [7:0]         blur_green,
  output logic [7:0]         blur_blue,
  output logic               frame_done
);
  import rbb_pkg::*;

  localparam int DEPTH  = RING_ROWS * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = COORD_W + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  function automatic logic [COORD_W-1:0] clamp(input logic signed [POS_W-1:0] v,
                                               input logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({2'b00, hi})) r = hi;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  logic [PIX_W-1:0] mem [DEPTH];

  logic [1:0]               state;
  logic [3:0]               cnt_x, cnt_y;
  logic signed [POS_W-1:0]  urow, ucol, ucol_start;
  logic [COORD_W-1:0]       crow, ccol, ccol_start;
  logic [RING_W-1:0]        ring;
  logic                     rd_valid, job_done;
  logic [PIX_W-1:0]         rd_data;
  logic [SUM_W-1:0]         sum_r, sum_g, sum_b;
  logic [RECIP_W-1:0]       recip;
  logic                     out_valid;

  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic signed [POS_W-1:0]  urow0, ucol0;
  logic [RING_W-1:0]        ring0;
  logic [COORD_W-1:0]       crow_next;
  logic                     last_tap, load_out;
  logic [SUM_W+RECIP_W-1:0] prod_r, prod_g, prod_b;

  assign q_pop   = (state == S_IDLE) && !q_empty;
  assign wr_addr = ADDR_W'(q_job.wr_ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(q_job.wr_col);
  assign rd_addr = ADDR_W'(ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ccol);

  assign urow0 = $signed({2'b00, q_job.out_row}) - $signed({{(POS_W-3){1'b0}}, geom.half});
  assign ucol0 = $signed({2'b00, q_job.out_col}) - $signed({{(POS_W-3){1'b0}}, geom.half});

  // ring slot of the top window row; rows above the frame clamp to row 0, slot 0
  always_comb begin
    if (urow0 < 0) ring0 = '0;
    else if (q_job.out_ring >= RING_W'(geom.half)) ring0 = q_job.out_ring - RING_W'(geom.half);
    else ring0 = q_job.out_ring + RING_W'(RING_ROWS) - RING_W'(geom.half);
  end

  assign crow_next = clamp(urow + 1'b1, geom.height - 1'b1);
  assign last_tap  = (cnt_x == geom.k - 1'b1) && (cnt_y == geom.k - 1'b1);
  assign load_out  = (state == S_DIV) && (!out_valid || pop);

  assign prod_r = (SUM_W+RECIP_W)'(sum_r) * (SUM_W+RECIP_W)'(recip);
  assign prod_g = (SUM_W+RECIP_W)'(sum_g) * (SUM_W+RECIP_W)'(recip);
  assign prod_b = (SUM_W+RECIP_W)'(sum_b) * (SUM_W+RECIP_W)'(recip);

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop && q_job.wr) begin
      mem[wr_addr] <= q_job.pixel;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_READ);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (q_pop && q_job.emit) state <= S_READ;
        S_READ: if (last_tap) state <= S_ACC;
        S_ACC:  state <= S_DIV;
        S_DIV:  if (load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // window walk: column inner, row outer, coordinates clamped to the frame
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      cnt_x      <= '0;
      cnt_y      <= '0;
      urow       <= urow0;
      crow       <= clamp(urow0, geom.height - 1'b1);
      ring       <= ring0;
      ucol       <= ucol0;
      ucol_start <= ucol0;
      ccol       <= clamp(ucol0, geom.width - 1'b1);
      ccol_start <= clamp(ucol0, geom.width - 1'b1);
      job_done   <= q_job.done;
      recip      <= area_recip(geom.k);
    end else if (state == S_READ) begin
      if (cnt_x == geom.k - 1'b1) begin
        cnt_x <= '0;
        cnt_y <= cnt_y + 1'b1;
        ucol  <= ucol_start;
        ccol  <= ccol_start;
        urow  <= urow + 1'b1;
        crow  <= crow_next;
        if (crow_next != crow) begin
          ring <= (ring == RING_W'(RING_ROWS-1)) ? '0 : ring + 1'b1;
        end
      end else begin
        cnt_x <= cnt_x + 1'b1;
        ucol  <= ucol + 1'b1;
        ccol  <= clamp(ucol + 1'b1, geom.width - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end else if (rd_valid) begin
      sum_r <= sum_r + SUM_W'(rd_data[7:0]);
      sum_g <= sum_g + SUM_W'(rd_data[15:8]);
      sum_b <= sum_b + SUM_W'(rd_data[23:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      blur_red   <= prod_r[RECIP_SHIFT +: 8];
      blur_green <= prod_g[RECIP_SHIFT +: 8];
      blur_blue  <= prod_b[RECIP_SHIFT +: 8];
      frame_done <= job_done;
    end
  end

endmodule

// ----- sv/rgb_box_blur_edge_clamp.sv -----
// A result passes through the queue and the back end's read, accumulate and divide states
// before it is registered on the result ports.
// Throughput: items that only store a pixel go in at one per cycle while the queue is
// not full; a result holds the back end and the single read port of the line store.
// A four-entry queue sits between the front end and the back end.
// Reset (rst, synchronous): registers return to 3x3, 640x480, all position counters
// and the queue clear; the line store is not cleared and is always written before read.
module rgb_box_blur_edge_clamp #(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048,
  parameter int MAX_KERNEL  = 13,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  blur_red,
  output logic [7:0]  blur_green,
  output logic [7:0]  blur_blue,
  output logic        frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import rbb_pkg::*;

  // ring of line rows: one more than the tallest window
  localparam int RING_ROWS = MAX_KERNEL + 1;

  logic [1:0]         kernel_select;
  logic [COORD_W-1:0] frame_width;
  logic [COORD_W-1:0] frame_height;

  logic       cfg_write, restart;
  logic [3:0] k_full;
  rbb_geom_t  geom;

  logic     q_push, q_full, q_pop, q_empty;
  rbb_job_t q_in, q_out;

  // config is always taken; index 3 is a no-op and does not restart the frame
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write && (cfg_index == REG_KERNEL || cfg_index == REG_WIDTH ||
                                   cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= 2'd0;
      frame_width   <= 12'd640;
      frame_height  <= 12'd480;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KERNEL: kernel_select <= cfg_data[1:0];
        REG_WIDTH:  frame_width   <= cfg_data;
        REG_HEIGHT: frame_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry: zero dims read as 1, large ones saturate, kernel limited
  assign k_full = window_dim(kernel_select);

  always_comb begin
    geom = '0;
    if (32'(k_full) > MAX_KERNEL) geom.k = 4'(MAX_KERNEL);
    else geom.k = k_full;
    geom.half = geom.k[3:1];

    if (frame_width == '0) geom.width = 12'd1;
    else if (32'(frame_width) > MAX_WIDTH) geom.width = COORD_W'(MAX_WIDTH);
    else geom.width = frame_width;

    if (frame_height == '0) geom.height = 12'd1;
    else if (32'(frame_height) > MAX_HEIGHT) geom.height = COORD_W'(MAX_HEIGHT);
    else geom.height = frame_height;

    // pixels that must be in before the first output: half rows plus half pixels
    geom.lead = LEAD_W'(geom.half) * LEAD_W'(geom.width) + LEAD_W'(geom.half);
  end

  rbb_front #(
    .RING_ROWS(RING_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .geom       (geom),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .pixel_red  (pixel_red),
    .pixel_green(pixel_green),
    .pixel_blue (pixel_blue),
    .q_push     (q_push),
    .q_job      (q_in),
    .q_full     (q_full)
  );

  rbb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (q_push),
    .wr_job(q_in),
    .full  (q_full),
    .rd_en (q_pop),
    .rd_job(q_out),
    .empty (q_empty)
  );

  rbb_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .RING_ROWS(RING_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .q_empty   (q_empty),
    .q_job     (q_out),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .blur_red  (blur_red),
    .blur_green(blur_green),
    .blur_blue (blur_blue),
    .frame_done(frame_done)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rbb_pkg::*;

  localparam int STORE_W   = 2048;
  localparam int STORE_H   = 2048;
  localparam int RING_ROWS = 14;
  localparam int SETTLE    = 800;    // > worst back-end time of ignored items in flight
  localparam int HOLD_LEN  = 400;    // long receiver hold-off, long enough to fill the block

  typedef struct {
    logic       op;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } stream_item_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       done;
  } blur_pix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        opcode = OP_PIXEL;
  logic [7:0]  pixel_red = '0;
  logic [7:0]  pixel_green = '0;
  logic [7:0]  pixel_blue = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  blur_red;
  logic [7:0]  blur_green;
  logic [7:0]  blur_blue;
  logic        frame_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  // pending stimulus and expected blur results
  stream_item_t pixel_feed[$];
  blur_pix_t    blur_due[$];

  // predictor state
  logic [23:0] ring_mem [RING_ROWS*STORE_W];
  logic [1:0]  sel_kern = 2'd0;
  logic [11:0] reg_w = 12'd640;
  logic [11:0] reg_h = 12'd480;
  int unsigned in_col, in_row, out_col, out_row;

  // run control
  int send_idle = 0;
  int recv_stall = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  int pix_sent = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int results_seen = 0;

  rgb_box_blur_edge_clamp i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .opcode(opcode), .pixel_red(pixel_red), .pixel_green(pixel_green),
    .pixel_blue(pixel_blue),
    .empty(empty), .pop(pop),
    .blur_red(blur_red), .blur_green(blur_green), .blur_blue(blur_blue),
    .frame_done(frame_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #12ms;
    $display("timeout waiting for the block");
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned clip_dim(input logic [11:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic int unsigned kern_of(input logic [1:0] sel);
    case (sel)
      2'd0: return 3;
      2'd1: return 5;
      2'd2: return 9;
      default: return 13;
    endcase
  endfunction

  function automatic int clampi(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic apply_cfg(input logic [1:0] idx, input logic [11:0] val);
    case (idx)
      REG_KERNEL: sel_kern = val[1:0];
      REG_WIDTH:  reg_w = val;
      REG_HEIGHT: reg_h = val;
      default: return;   // unused index: no effect at all
    endcase
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  // One accepted stream transaction: update the window state, queue the blur it emits.
  task automatic blur_predict(input stream_item_t it);
    int unsigned w, h, k, half, rcv;
    int unsigned sr, sg, sb, row, col;
    logic [23:0] p;
    blur_pix_t res;
    w = clip_dim(reg_w, STORE_W);
    h = clip_dim(reg_h, STORE_H);
    k = kern_of(sel_kern);
    half = k / 2;
    sr = 0; sg = 0; sb = 0;
    if (it.op == OP_PIXEL) begin
      if (in_row >= h) return;   // frame input already complete
      ring_mem[(in_row % RING_ROWS)*STORE_W + in_col] = {it.b, it.g, it.r};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      rcv = in_row*w + in_col;
      if (rcv <= half*w + half) return;
    end else if (in_row < h) begin
      return;                    // drain too early
    end
    for (int dy = -int'(half); dy < int'(k) - int'(half); dy++) begin
      row = clampi(int'(out_row) + dy, int'(h) - 1);
      for (int dx = -int'(half); dx < int'(k) - int'(half); dx++) begin
        col = clampi(int'(out_col) + dx, int'(w) - 1);
        p = ring_mem[(row % RING_ROWS)*STORE_W + col];
        sr += 32'(p[7:0]);
        sg += 32'(p[15:8]);
        sb += 32'(p[23:16]);
      end
    end
    res.done = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) begin
        res.done = 1'b1;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
    end
    res.r = 8'(sr / (k*k));
    res.g = 8'(sg / (k*k));
    res.b = 8'(sb / (k*k));
    blur_due.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Driver: feeds stream transactions from pixel_feed.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        blur_predict(pixel_feed.pop_front());
      end
      if (push && full) begin
        push <= 1'b1;            // hold the offered item until taken
      end else if (pixel_feed.size() > 0 && $urandom_range(99) >= send_idle) begin
        push        <= 1'b1;
        opcode      <= pixel_feed[0].op;
        pixel_red   <= pixel_feed[0].r;
        pixel_green <= pixel_feed[0].g;
        pixel_blue  <= pixel_feed[0].b;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in cycles.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each popped blur pixel against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (blur_due.size() == 0) begin
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          blur_pix_t e;
          e = blur_due.pop_front();
          if (blur_red !== e.r) report_mismatch("blur_red", int'(blur_red), int'(e.r));
          if (blur_green !== e.g) report_mismatch("blur_green", int'(blur_green), int'(e.g));
          if (blur_blue !== e.b) report_mismatch("blur_blue", int'(blur_blue), int'(e.b));
          if (frame_done !== e.done) begin
            report_mismatch("frame_done", int'(frame_done), int'(e.done));
          end
        end
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pixel_feed.size() != 0 || blur_due.size() != 0 || push) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // pattern: 0 random, 1 all zero, 2 all ones
  task automatic queue_frame(input int pattern, input bit noise);
    int unsigned w, h, half, n, drains;
    stream_item_t it;
    w = clip_dim(reg_w, STORE_W);
    h = clip_dim(reg_h, STORE_H);
    half = kern_of(sel_kern) / 2;
    n = w * h;
    drains = (half*w + half < n) ? half*w + half : n;
    if (noise) begin
      it = '{OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom)};
      pixel_feed.push_back(it);  // drain before frame end: dropped
      items_sent++;
    end
    for (int i = 0; i < int'(n); i++) begin
      it.op = OP_PIXEL;
      case (pattern)
        1: begin it.r = 8'h00; it.g = 8'h00; it.b = 8'h00; end
        2: begin it.r = 8'hff; it.g = 8'hff; it.b = 8'hff; end
        default: begin
          it.r = 8'($urandom); it.g = 8'($urandom); it.b = 8'($urandom);
        end
      endcase
      pixel_feed.push_back(it);
    end
    pix_sent += int'(n);
    items_sent += int'(n);
    frames_sent++;
    for (int i = 0; i < int'(drains); i++) begin
      if (noise && i == 0) begin
        it = '{OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom)};
        pixel_feed.push_back(it);  // pixel after input complete: dropped
        items_sent++;
      end
      it = '{OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom)};
      pixel_feed.push_back(it);
      items_sent++;
    end
  endtask

  // start of a frame only; the next register write restarts the frame
  task automatic queue_partial(input int count);
    stream_item_t it;
    for (int i = 0; i < count; i++) begin
      it = '{OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom)};
      pixel_feed.push_back(it);
    end
    pix_sent += count;
    items_sent += count;
  endtask

  task automatic set_idle(input int mode);
    case (mode % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 64; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 64; end
      default: begin send_idle = 30; recv_stall = 30; end
    endcase
  endtask

  initial begin
    int iter;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: zero sizes clamp to 1x1, pixel extremes, every kernel
    set_idle(0);
    cfg_write(REG_KERNEL, 12'd0);
    cfg_write(REG_WIDTH, 12'd0);
    cfg_write(REG_HEIGHT, 12'd0);
    queue_frame(1, 1'b0);
    queue_frame(2, 1'b1);
    settle();
    cfg_write(2'd3, 12'($urandom));   // unused index, must change nothing
    queue_frame(0, 1'b0);
    settle();
    cfg_write(REG_WIDTH, 12'd3);
    cfg_write(REG_HEIGHT, 12'd3);
    queue_frame(2, 1'b0);
    settle();
    for (int s = 1; s < 4; s++) begin
      cfg_write(REG_KERNEL, 12'(s));
      queue_frame(0, 1'b1);
      settle();
    end
    cfg_write(REG_KERNEL, 12'hffd);     // upper bits dropped: selects 5x5
    queue_frame(2, 1'b0);
    settle();

    // oversize width and height: start of a frame, then cut short by a write
    cfg_write(REG_KERNEL, 12'd0);
    cfg_write(REG_WIDTH, 12'hfff);
    cfg_write(REG_HEIGHT, 12'd1);
    queue_partial(60);
    settle();
    cfg_write(REG_WIDTH, 12'd1);
    cfg_write(REG_HEIGHT, 12'hfff);
    queue_partial(60);
    settle();

    // back-pressure: receiver holds off while the sender keeps pushing
    cfg_write(REG_WIDTH, 12'd12);
    cfg_write(REG_HEIGHT, 12'd10);
    queue_frame(0, 1'b0);
    hold_req++;
    settle();

    // random frames across all idle profiles
    iter = 0;
    while (items_sent < 800) begin
      set_idle(iter);
      cfg_write(REG_KERNEL, 12'($urandom_range(3)));
      cfg_write(REG_WIDTH, 12'($urandom_range(12, 1)));
      cfg_write(REG_HEIGHT, 12'($urandom_range(10, 1)));
      repeat ($urandom_range(3, 1)) queue_frame(0, $urandom_range(3) == 0);
      settle();
      iter++;
    end

    $display("covered %0d frames, %0d items (%0d pixels), %0d blur results checked",
             frames_sent, items_sent, pix_sent, results_seen);
    $display("kernels 3/5/9/13, frames 1x1 to 12x10, oversize geometry, idle and stall mixes");
    if (errors == 0 && blur_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
